@@ hw/rtl/brbuf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and pointer helpers for the byte ring buffer.
// Used by brbuf_store and byte_ring_buffer_sample_drain_core; no dependencies.
package brbuf_pkg;

	// Capacity in bytes (4..128)
	localparam int BUFFER_BYTES = 128;

	// Pointers count modulo twice the capacity
	localparam int PTR_W  = $clog2(2 * BUFFER_BYTES);
	localparam int SLOT_W = $clog2(BUFFER_BYTES);
	// Sample count of one drain: at most BUFFER_BYTES / 2
	localparam int REM_W  = PTR_W - 1;

	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(2 * BUFFER_BYTES - 1);
	localparam logic [PTR_W-1:0] PTR_CAP  = PTR_W'(BUFFER_BYTES);
	localparam logic [PTR_W:0]   PTR_MOD  = (PTR_W + 1)'(2 * BUFFER_BYTES);

	// Request kinds
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_DRAIN = 2'd1;
	localparam logic [1:0] KIND_RESET = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic       first_of_call;
	} cmd_t;

	typedef struct packed {
		logic               accepted;
		logic signed [15:0] sample;
		logic               sample_valid;
		logic               last;
		logic [7:0]         fill_bytes;
		logic               overflow;
	} rsp_t;

	// Pointer step with wrap at twice the capacity
	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		if (p == PTR_LAST) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	// Buffer slot of a pointer; the pointer is below twice the capacity
	function automatic logic [SLOT_W-1:0] slot_of(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] d;
		d = p - PTR_CAP;
		if (p >= PTR_CAP) begin
			return d[SLOT_W-1:0];
		end
		return p[SLOT_W-1:0];
	endfunction

	// Bytes held: write minus read pointer, modulo twice the capacity
	function automatic logic [PTR_W-1:0] fill_of(input logic [PTR_W-1:0] wp,
			input logic [PTR_W-1:0] rp);
		logic [PTR_W:0] d;
		d = {1'b0, wp} - {1'b0, rp};
		if (d[PTR_W]) begin
			d = d + PTR_MOD;
		end
		return d[PTR_W-1:0];
	endfunction

endpackage

@@ hw/rtl/brbuf_store.sv @@
`timescale 1ns / 1ps
// Byte store of the ring buffer: one write port, two registered read ports.
// Depends on brbuf_pkg for the depth and slot width.
module brbuf_store (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [brbuf_pkg::SLOT_W-1:0] wr_addr,
	input  logic [7:0]                  wr_data,
	input  logic                        rd_en,
	input  logic [brbuf_pkg::SLOT_W-1:0] rd_addr_lo,
	input  logic [brbuf_pkg::SLOT_W-1:0] rd_addr_hi,
	output logic [7:0]                  rd_data_lo,
	output logic [7:0]                  rd_data_hi
);

	logic [7:0] mem [brbuf_pkg::BUFFER_BYTES];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read ports, data held until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_lo <= mem[rd_addr_lo];
			rd_data_hi <= mem[rd_addr_hi];
		end
	end

endmodule

@@ hw/rtl/byte_ring_buffer_sample_drain_core.sv @@
`timescale 1ns / 1ps
// Byte ring buffer with 16-bit sample drain: top level.
// Depends on brbuf_pkg and brbuf_store.

// A write, pointer reset or unused request gives one response; a new request
// is taken in the next cycle as long as the response register is free or being
// emptied. A drain of N complete samples (N up to BUFFER_BYTES/2) gives N
// responses, one per cycle while the response is not stalled, low byte first,
// the last marked; each sample is read from the byte store, whose two read
// ports hand over both bytes in the cycle after the read is issued, and the
// next request is taken once the final sample has reached the response
// register. A drain with fewer than two bytes held answers at once with one
// empty response. The overflow flag is sticky and is cleared only by the
// asynchronous reset; a pointer reset request empties the buffer without
// touching it.
module byte_ring_buffer_sample_drain_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  brbuf_pkg::cmd_t  cmd,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output brbuf_pkg::rsp_t  rsp
);

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} state_t;

	state_t                       state_q;
	logic [brbuf_pkg::PTR_W-1:0]  wp_q;
	logic [brbuf_pkg::PTR_W-1:0]  rp_q;
	logic                         ovf_q;
	logic [brbuf_pkg::REM_W-1:0]  rem_q;
	brbuf_pkg::rsp_t              rsp_q;
	logic                         rsp_valid_q;

	// Read stage: bytes arrive from the store in the cycle after issue
	logic                         rd_vld_s1;
	logic                         last_s1;
	logic [brbuf_pkg::PTR_W-1:0]  fill_s1;
	logic [7:0]                   lo_byte;
	logic [7:0]                   hi_byte;

	logic                         cmd_take;
	logic                         out_free;
	logic                         s1_move;
	logic                         issue;
	logic [brbuf_pkg::PTR_W-1:0]  fill_cur;
	logic [brbuf_pkg::PTR_W-1:0]  rp_plus1;
	logic [brbuf_pkg::PTR_W-1:0]  rp_plus2;
	logic [brbuf_pkg::REM_W-1:0]  samples;
	logic                         room;
	logic                         wr_en;
	logic                         drain_run;
	logic                         ovf_next;
	brbuf_pkg::rsp_t              imm_rsp;

	// Handshake and flow control
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = (state_q != ST_IDLE) || rd_vld_s1 || (rsp_valid_q && rsp_stall);
	assign cmd_take  = cmd_valid && !cmd_stall;
	assign s1_move   = rd_vld_s1 && out_free;
	assign issue     = (state_q == ST_DRAIN) && (!rd_vld_s1 || s1_move);

	// Fill level and pointer arithmetic
	assign fill_cur  = brbuf_pkg::fill_of(wp_q, rp_q);
	assign room      = fill_cur < brbuf_pkg::PTR_CAP;
	assign samples   = fill_cur[brbuf_pkg::PTR_W-1:1];
	assign rp_plus1  = brbuf_pkg::ptr_inc(rp_q);
	assign rp_plus2  = brbuf_pkg::ptr_inc(rp_plus1);
	assign wr_en     = cmd_take && (cmd.kind == brbuf_pkg::KIND_WRITE) && room;
	assign drain_run = (cmd.kind == brbuf_pkg::KIND_DRAIN) && (samples != '0);
	assign ovf_next  = ovf_q || ((cmd.kind == brbuf_pkg::KIND_WRITE) && !room
		&& cmd.first_of_call);

	brbuf_store u_store (
		.clk        (clk),
		.wr_en      (wr_en),
		.wr_addr    (brbuf_pkg::slot_of(wp_q)),
		.wr_data    (cmd.data_byte),
		.rd_en      (issue),
		.rd_addr_lo (brbuf_pkg::slot_of(rp_q)),
		.rd_addr_hi (brbuf_pkg::slot_of(rp_plus1)),
		.rd_data_lo (lo_byte),
		.rd_data_hi (hi_byte)
	);

	// Single-response items: write, empty drain, pointer reset, unused kind
	always_comb begin
		imm_rsp              = '0;
		imm_rsp.last         = 1'b1;
		imm_rsp.overflow     = ovf_next;
		imm_rsp.fill_bytes   = 8'(fill_cur);
		case (cmd.kind)
			brbuf_pkg::KIND_WRITE: begin
				imm_rsp.accepted   = room;
				imm_rsp.fill_bytes = 8'(fill_cur + brbuf_pkg::PTR_W'(room));
			end
			brbuf_pkg::KIND_RESET: begin
				imm_rsp.fill_bytes = '0;
			end
			default: begin
			end
		endcase
	end

	// State, pointers, read stage and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			rp_q        <= '0;
			ovf_q       <= 1'b0;
			rem_q       <= '0;
			rd_vld_s1   <= 1'b0;
			last_s1     <= 1'b0;
			fill_s1     <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (cmd_take) begin
				ovf_q <= ovf_next;
				case (cmd.kind)
					brbuf_pkg::KIND_WRITE: begin
						if (room) begin
							wp_q <= brbuf_pkg::ptr_inc(wp_q);
						end
					end
					brbuf_pkg::KIND_DRAIN: begin
						if (samples != '0) begin
							state_q <= ST_DRAIN;
							rem_q   <= samples;
						end
					end
					brbuf_pkg::KIND_RESET: begin
						wp_q <= '0;
						rp_q <= '0;
					end
					default: begin
					end
				endcase
				if (!drain_run) begin
					rsp_q <= imm_rsp;
				end
			end

			// Issue the read of one sample
			if (issue) begin
				rp_q      <= rp_plus2;
				rem_q     <= rem_q - brbuf_pkg::REM_W'(1);
				last_s1   <= (rem_q == brbuf_pkg::REM_W'(1));
				fill_s1   <= brbuf_pkg::fill_of(wp_q, rp_plus2);
				rd_vld_s1 <= 1'b1;
				if (rem_q == brbuf_pkg::REM_W'(1)) begin
					state_q <= ST_IDLE;
				end
			end else if (s1_move) begin
				rd_vld_s1 <= 1'b0;
			end

			// Sample into the response register
			if (s1_move) begin
				rsp_q.accepted     <= 1'b0;
				rsp_q.sample       <= $signed({hi_byte, lo_byte});
				rsp_q.sample_valid <= 1'b1;
				rsp_q.last         <= last_s1;
				rsp_q.fill_bytes   <= 8'(fill_s1);
				rsp_q.overflow     <= ovf_q;
			end

			// Response valid: set by a new response, cleared once taken
			if ((cmd_take && !drain_run) || s1_move) begin
				rsp_valid_q <= 1'b1;
			end else if (out_free) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
